>>> hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, with reset masking it off.
`define GDTC_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");

// Check a property on every rising edge, reset included.
`define GDTC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion failed");

`endif

>>> hw/rtl/gdtc_pkg.sv
package gdtc_pkg;

  // Largest graph the block is built for, by default
  localparam int unsigned MaxVerticesDefault = 64;

  // Fixed field widths
  localparam int unsigned RowWidth      = 64;
  localparam int unsigned CfgWidth      = 7;
  localparam int unsigned OutTdataWidth = 8;

  // One check result
  typedef struct packed {
    logic is_complete;
    logic diameter_two;
  } result_t;

endpackage

>>> hw/rtl/graph_diameter_two_check.sv
// Diameter-two check over an undirected graph of up to MaxVertices vertices.
// Write vertex_count (n) on cfg_we_i/cfg_wdata_i while idle; 0 counts as 1 and
// values above MaxVertices count as MaxVertices, and a write restarts loading.
// Then stream n adjacency rows, one per transfer and one per cycle, bit u of
// row v set for an edge v-u; bits at or above n are ignored. After the last
// row the input closes while the check sweeps the row store through its
// single read port: for each vertex v it reads row v, then scans every row u
// and merges row u into v's reached set when u neighbours v. The one result
// then sits in an output register and the next graph may load while it waits.
// tdata bit 0 is diameter_two, bit 1 is is_complete; a complete graph
// reports is_complete and not diameter_two.
module graph_diameter_two_check #(
  parameter int unsigned MaxVertices = gdtc_pkg::MaxVerticesDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gdtc_pkg::CfgWidth-1:0]      cfg_wdata_i,   // [6:0] vertex_count
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [gdtc_pkg::RowWidth-1:0]      s_axis_tdata_i, // [63:0] row_bits
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [gdtc_pkg::OutTdataWidth-1:0] m_axis_tdata_o  // [0] diameter_two,
                                                             // [1] is_complete
);

  localparam int unsigned AddrWidth = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;

  logic                          mem_we;
  logic [AddrWidth-1:0]          mem_waddr;
  logic [AddrWidth-1:0]          mem_raddr;
  logic [gdtc_pkg::RowWidth-1:0] mem_rdata;
  gdtc_pkg::result_t             result;

  gdtc_ctrl #(
    .MaxVertices (MaxVertices)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_result_o (result),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  gdtc_row_mem #(
    .MaxVertices (MaxVertices)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Pack the result, zero-filled to a byte
  assign m_axis_tdata_o = {{(gdtc_pkg::OutTdataWidth - 2){1'b0}},
                           result.is_complete, result.diameter_two};

endmodule

>>> hw/rtl/gdtc_row_mem.sv
// Adjacency row store: one write port, one read port, registered read data.
module gdtc_row_mem #(
  parameter int unsigned MaxVertices = gdtc_pkg::MaxVerticesDefault,
  localparam int unsigned AddrWidth  = (MaxVertices > 1) ? $clog2(MaxVertices) : 1
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AddrWidth-1:0]          waddr_i,
  input  logic [gdtc_pkg::RowWidth-1:0] wdata_i,
  input  logic [AddrWidth-1:0]          raddr_i,
  output logic [gdtc_pkg::RowWidth-1:0] rdata_o
);

  logic [gdtc_pkg::RowWidth-1:0] mem [MaxVertices];
  logic [gdtc_pkg::RowWidth-1:0] rdata_q;

  // Store incoming rows
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read one row per cycle
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/gdtc_ctrl.sv
// Load sequencer and two-step reachability sweep over the row store.
module gdtc_ctrl #(
  parameter int unsigned MaxVertices = gdtc_pkg::MaxVerticesDefault,
  localparam int unsigned AddrWidth  = (MaxVertices > 1) ? $clog2(MaxVertices) : 1,
  localparam int unsigned CntWidth   = $clog2(MaxVertices + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gdtc_pkg::CfgWidth-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output gdtc_pkg::result_t             out_result_o,
  output logic                          mem_we_o,
  output logic [AddrWidth-1:0]          mem_waddr_o,
  output logic [AddrWidth-1:0]          mem_raddr_o,
  input  logic [gdtc_pkg::RowWidth-1:0] mem_rdata_i
);

  localparam logic [2:0] StLoad   = 3'd0;
  localparam logic [2:0] StOwnRd  = 3'd1;
  localparam logic [2:0] StOwnCap = 3'd2;
  localparam logic [2:0] StScan   = 3'd3;
  localparam logic [2:0] StOut    = 3'd4;

  localparam logic [gdtc_pkg::CfgWidth-1:0] CfgMax = gdtc_pkg::CfgWidth'(MaxVertices);

  logic [2:0]                    state_q, state_d;
  logic [gdtc_pkg::CfgWidth-1:0] count_cfg_q, count_cfg_d;
  logic [CntWidth-1:0]           rows_q, rows_d;
  logic [AddrWidth-1:0]          v_q, v_d;
  logic [AddrWidth-1:0]          u_q, u_d;
  logic [gdtc_pkg::RowWidth-1:0] own_q, own_d;
  logic [gdtc_pkg::RowWidth-1:0] reached_q, reached_d;
  logic                          pass_q, pass_d;
  logic                          nonedge_q, nonedge_d;
  logic                          out_valid_q, out_valid_d;
  gdtc_pkg::result_t             out_result_q, out_result_d;

  logic [CntWidth-1:0]           n_eff;
  logic [CntWidth-1:0]           n_last;
  logic [gdtc_pkg::RowWidth-1:0] all_mask;
  logic [gdtc_pkg::RowWidth-1:0] v_bit;
  logic [gdtc_pkg::RowWidth-1:0] row_masked;
  logic [gdtc_pkg::RowWidth-1:0] closed;
  logic [gdtc_pkg::RowWidth-1:0] reached_next;
  logic                          in_xfer;
  logic                          last_row;
  logic                          last_u;
  logic                          last_v;

  // Clamp the configured count into 1..MaxVertices
  always_comb begin
    priority if (count_cfg_q == '0) begin
      n_eff = CntWidth'(1);
    end else if (count_cfg_q >= CfgMax) begin
      n_eff = CntWidth'(MaxVertices);
    end else begin
      n_eff = count_cfg_q[CntWidth-1:0];
    end
  end

  assign n_last = n_eff - CntWidth'(1);

  // Mask of live vertices and the one-hot of the current vertex
  always_comb begin
    for (int i = 0; i < gdtc_pkg::RowWidth; i++) begin
      all_mask[i] = (i < int'(n_eff));
      v_bit[i]    = (i == int'(v_q));
    end
  end

  assign row_masked   = mem_rdata_i & all_mask;
  assign closed       = row_masked | v_bit;
  assign reached_next = own_q[u_q] ? (reached_q | row_masked) : reached_q;

  assign in_ready_o = (state_q == StLoad);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign last_row   = ((rows_q + CntWidth'(1)) == n_eff);
  assign last_u     = (CntWidth'(u_q) == n_last);
  assign last_v     = (CntWidth'(v_q) == n_last);

  // Row writes only while loading; read data is used only while checking
  assign mem_we_o    = in_xfer;
  assign mem_waddr_o = rows_q[AddrWidth-1:0];

  always_comb begin
    unique case (state_q)
      StOwnRd:  mem_raddr_o = v_q;
      StOwnCap: mem_raddr_o = '0;
      StScan:   mem_raddr_o = u_q + AddrWidth'(1);
      default:  mem_raddr_o = v_q;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    count_cfg_d  = count_cfg_q;
    rows_d       = rows_q;
    v_d          = v_q;
    u_d          = u_q;
    own_d        = own_q;
    reached_d    = reached_q;
    pass_d       = pass_q;
    nonedge_d    = nonedge_q;
    out_result_d = out_result_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    unique case (state_q)
      StLoad: begin
        if (cfg_we_i) begin
          count_cfg_d = cfg_wdata_i;
          rows_d      = '0;
        end else if (in_xfer) begin
          if (last_row) begin
            rows_d    = '0;
            v_d       = '0;
            pass_d    = 1'b1;
            nonedge_d = 1'b0;
            state_d   = StOwnRd;
          end else begin
            rows_d = rows_q + CntWidth'(1);
          end
        end
      end
      StOwnRd: begin
        state_d = StOwnCap;
      end
      StOwnCap: begin
        own_d     = row_masked;
        reached_d = closed;
        nonedge_d = nonedge_q || (closed != all_mask);
        u_d       = '0;
        state_d   = StScan;
      end
      StScan: begin
        reached_d = reached_next;
        if (last_u) begin
          pass_d = pass_q && (reached_next == all_mask);
          if (last_v) begin
            state_d = StOut;
          end else begin
            v_d     = v_q + AddrWidth'(1);
            state_d = StOwnRd;
          end
        end else begin
          u_d = u_q + AddrWidth'(1);
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d               = 1'b1;
          out_result_d.diameter_two = pass_q && nonedge_q;
          out_result_d.is_complete  = !nonedge_q;
          state_d                   = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      count_cfg_q <= gdtc_pkg::CfgWidth'(64);
      rows_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_cfg_q <= count_cfg_d;
      rows_q      <= rows_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sweep data path
  always_ff @(posedge clk_i) begin
    v_q          <= v_d;
    u_q          <= u_d;
    own_q        <= own_d;
    reached_q    <= reached_d;
    pass_q       <= pass_d;
    nonedge_q    <= nonedge_d;
    out_result_q <= out_result_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_result_q;

endmodule

>>> hw/rtl/gdtc_checker.sv
`include "assert_macros.svh"

// Port-level checks for the diameter-two block.
module gdtc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tready_o,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [gdtc_pkg::OutTdataWidth-1:0] m_axis_tdata_o
);

  // Hold a result until it is taken
  `GDTC_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // A complete graph never reports diameter two
  `GDTC_ASSERT(a_complete_excl, clk_i, rst_ni, m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))

  // A new result only follows a check sweep, during which input is closed
  `GDTC_ASSERT(a_result_after_sweep, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))

  // No result pending once reset has been applied
  `GDTC_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !m_axis_tvalid_o)

endmodule

bind graph_diameter_two_check gdtc_checker u_gdtc_checker (.*);
